[rtl/gsob_pkg.sv]
// Shared constants, types and helpers for the glyph source-over blender.
package gsob_pkg;

    localparam int ChanN     = 3;            // red, green, blue
    localparam int ColW      = 8;
    localparam int ProdW     = 2 * ColW;     // 8x8 product
    localparam int NumW      = 3 * ColW;     // color numerator, max 255^3
    localparam int DenW      = 2 * ColW;     // oa * 255
    localparam int QW        = ColW;         // quotient bits after saturation check
    localparam int DivStages = QW + 1;       // saturation check plus one bit per stage

    localparam logic [ColW-1:0] CoverMin = 8'd3;
    localparam logic [ColW-1:0] ColMax   = 8'hFF;

    typedef enum logic [1:0] {
        CFG_RED   = 2'd0,
        CFG_GREEN = 2'd1,
        CFG_BLUE  = 2'd2,
        CFG_ALPHA = 2'd3
    } t_cfg_idx;

    // data that rides alongside the divider
    typedef struct packed {
        logic [ColW-1:0]            alpha;
        logic                       written;
        logic                       zero;
        logic [ChanN-1:0][ColW-1:0] dst;
    } t_side;

    // floor(x / 255) for x up to 255*255
    function automatic logic [ColW-1:0] div255(input logic [ProdW-1:0] x);
        logic [ProdW:0] s;
        s = {1'b0, x} + {{(ColW+1){1'b0}}, x[ProdW-1:ColW]} + {{ProdW{1'b0}}, 1'b1};
        return s[ProdW-1:ColW];
    endfunction

endpackage

[rtl/gsob_div.sv]
// Pipelined restoring divider, three color lanes, one quotient bit per stage.
module gsob_div (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic [gsob_pkg::ChanN-1:0][gsob_pkg::NumW-1:0] i_num,
    input  logic [gsob_pkg::DenW-1:0]                      i_den,
    input  gsob_pkg::t_side                                i_side,
    output logic                                           o_valid,
    input  logic                                           i_ready,
    output logic [gsob_pkg::ChanN-1:0][gsob_pkg::ColW-1:0] o_color,
    output gsob_pkg::t_side                                o_side
);
    import gsob_pkg::*;

    logic [DivStages-1:0] r_vld;
    logic [DivStages:0]   w_rdy;

    logic [NumW-1:0] r_rem  [QW][ChanN];
    logic            r_sat  [QW][ChanN];
    logic [QW-1:0]   r_q    [QW][ChanN];   // stage s kept at index s-1
    logic [DenW-1:0] r_den  [QW];
    t_side           r_side [DivStages];

    always_comb begin
        w_rdy[DivStages] = i_ready;
        for (int s = DivStages - 1; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < DivStages; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // stage 0: saturation check, quotient >= 256
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int c = 0; c < ChanN; c++) begin
                r_rem[0][c] <= i_num[c];
                r_sat[0][c] <= i_num[c] >= {i_den, {QW{1'b0}}};
            end
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar s = 1; s < DivStages; s++) begin : g_stage
        localparam int Bit = QW - s;

        logic [NumW-1:0] w_dsh;
        logic [NumW-1:0] w_rem_n [ChanN];
        logic [QW-1:0]   w_q_n   [ChanN];
        logic [QW-1:0]   w_q_p   [ChanN];

        assign w_dsh = {{(NumW-DenW){1'b0}}, r_den[s-1]} << Bit;

        always_comb begin
            for (int c = 0; c < ChanN; c++) begin
                w_q_p[c] = (s == 1) ? '0 : r_q[(s >= 2) ? s - 2 : 0][c];
                if (r_rem[s-1][c] >= w_dsh) begin
                    w_rem_n[c] = r_rem[s-1][c] - w_dsh;
                    w_q_n[c]   = w_q_p[c] | ({{(QW-1){1'b0}}, 1'b1} << Bit);
                end else begin
                    w_rem_n[c] = r_rem[s-1][c];
                    w_q_n[c]   = w_q_p[c];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s]) begin
                r_side[s] <= r_side[s-1];
                for (int c = 0; c < ChanN; c++) begin
                    if (s == QW) begin
                        // final pick: skipped pixel, zero alpha, saturated, quotient
                        if (!r_side[s-1].written) begin
                            r_q[s-1][c] <= r_side[s-1].dst[c];
                        end else if (r_side[s-1].zero) begin
                            r_q[s-1][c] <= '0;
                        end else if (r_sat[s-1][c]) begin
                            r_q[s-1][c] <= ColMax;
                        end else begin
                            r_q[s-1][c] <= w_q_n[c];
                        end
                    end else begin
                        r_q[s-1][c] <= w_q_n[c];
                    end
                end
            end
        end

        if (s < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_rdy[s]) begin
                    r_den[s] <= r_den[s-1];
                    for (int c = 0; c < ChanN; c++) begin
                        r_rem[s][c] <= w_rem_n[c];
                        r_sat[s][c] <= r_sat[s-1][c];
                    end
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[DivStages-1];
    assign o_side  = r_side[DivStages-1];

    always_comb begin
        for (int c = 0; c < ChanN; c++) begin
            o_color[c] = r_q[QW-1][c];
        end
    end

endmodule

[rtl/glyph_source_over_blend.sv]
// Glyph source-over blender: top level with config registers and the alpha front end.
// Takes one pixel word per clock while s_axis_tready is high; returns one blended word
// per pixel, in order. Four front stages form the source alpha, output alpha
// and color numerators, then a nine-stage divider checks saturation and resolves
// one quotient bit per stage for all three colors. Every stage holds a valid bit
// and fills bubbles, so input is taken while a result waits as long as any stage
// is empty. Coverage below 3 passes the destination through with tuser low.
// Config writes are taken at any time but belong between frames.
module glyph_source_over_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // coverage, dst_red, dst_green, dst_blue, dst_alpha
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, blend_alpha
    output logic [0:0]  m_axis_tuser    // written
);
    import gsob_pkg::*;

    logic [ChanN-1:0][ColW-1:0] r_text;
    logic [ColW-1:0]            r_text_alpha;

    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_div_rdy;

    logic                       r1_vld, r1_skip;
    logic [ProdW-1:0]           r1_prod;
    logic [ChanN-1:0][ColW-1:0] r1_dst;
    logic [ColW-1:0]            r1_da;

    logic                       r2_vld, r2_skip;
    logic [ColW-1:0]            r2_sa;
    logic [ChanN-1:0][ColW-1:0] r2_dst;
    logic [ColW-1:0]            r2_da;

    logic                        r3_vld, r3_skip;
    logic [ColW-1:0]             r3_sa;
    logic [ProdW-1:0]            r3_dad;
    logic [ChanN-1:0][ProdW-1:0] r3_tcsa;
    logic [ChanN-1:0][ColW-1:0]  r3_dst;
    logic [ColW-1:0]             r3_da;

    logic                       r4_vld, r4_skip;
    logic [ColW-1:0]            r4_oa;
    logic [ChanN-1:0][NumW-1:0] r4_num;
    logic [ChanN-1:0][ColW-1:0] r4_dst;
    logic [ColW-1:0]            r4_da;

    logic [ColW-1:0]            w_inv;
    logic [ColW-1:0]            w_oa;
    logic [ChanN-1:0][NumW-1:0] w_num;
    logic [DenW-1:0]            w_den;
    t_side                      w_side;
    t_side                      w_out_side;
    logic [ChanN-1:0][ColW-1:0] w_out_color;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text       <= {ChanN{ColMax}};
            r_text_alpha <= ColMax;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RED:   r_text[0]    <= i_cfg_data;
                CFG_GREEN: r_text[1]    <= i_cfg_data;
                CFG_BLUE:  r_text[2]    <= i_cfg_data;
                CFG_ALPHA: r_text_alpha <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    assign w_rdy4 = !r4_vld || w_div_rdy;
    assign w_rdy3 = !r3_vld || w_rdy4;
    assign w_rdy2 = !r2_vld || w_rdy3;
    assign w_rdy1 = !r1_vld || w_rdy2;
    assign s_axis_tready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else begin
            if (w_rdy1) r1_vld <= s_axis_tvalid;
            if (w_rdy2) r2_vld <= r1_vld;
            if (w_rdy3) r3_vld <= r2_vld;
            if (w_rdy4) r4_vld <= r3_vld;
        end
    end

    // stage 1: text_alpha * coverage
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_prod <= ProdW'(r_text_alpha) * ProdW'(s_axis_tdata[7:0]);
            r1_skip <= s_axis_tdata[7:0] < CoverMin;
            r1_dst  <= s_axis_tdata[31:8];
            r1_da   <= s_axis_tdata[39:32];
        end
    end

    // stage 2: source alpha
    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_sa   <= div255(r1_prod);
            r2_skip <= r1_skip;
            r2_dst  <= r1_dst;
            r2_da   <= r1_da;
        end
    end

    // stage 3: dst_alpha*(255-sa) and text color * sa
    assign w_inv = ColMax - r2_sa;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_dad <= ProdW'(r2_da) * ProdW'(w_inv);
            for (int c = 0; c < ChanN; c++) begin
                r3_tcsa[c] <= ProdW'(r_text[c]) * ProdW'(r2_sa);
            end
            r3_sa   <= r2_sa;
            r3_skip <= r2_skip;
            r3_dst  <= r2_dst;
            r3_da   <= r2_da;
        end
    end

    // stage 4: output alpha and color numerators
    assign w_oa = r3_sa + div255(r3_dad);

    always_comb begin
        for (int c = 0; c < ChanN; c++) begin
            w_num[c] = ({r3_tcsa[c], {ColW{1'b0}}} - {{ColW{1'b0}}, r3_tcsa[c]})
                     + NumW'(r3_dst[c]) * NumW'(r3_dad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r4_oa   <= w_oa;
            r4_num  <= w_num;
            r4_skip <= r3_skip;
            r4_dst  <= r3_dst;
            r4_da   <= r3_da;
        end
    end

    // divisor oa * 255
    assign w_den = {r4_oa, {ColW{1'b0}}} - {{ColW{1'b0}}, r4_oa};

    assign w_side.alpha   = r4_skip ? r4_da : r4_oa;
    assign w_side.written = !r4_skip;
    assign w_side.zero    = r4_oa == '0;
    assign w_side.dst     = r4_dst;

    gsob_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_vld),
        .o_ready (w_div_rdy),
        .i_num   (r4_num),
        .i_den   (w_den),
        .i_side  (w_side),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_color (w_out_color),
        .o_side  (w_out_side)
    );

    assign m_axis_tdata = {w_out_side.alpha, w_out_color};
    assign m_axis_tuser = w_out_side.written;

    // a blended word with zero alpha carries black
    a_zero_alpha_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] && m_axis_tdata[31:24] == 8'd0
        |-> m_axis_tdata[23:0] == 24'd0)
        else $error("blended word with zero alpha has nonzero color");

    // a held first stage keeps its product
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_vld && !w_rdy2 |=> r1_vld && $stable(r1_prod) && $stable(r1_skip))
        else $error("first stage changed while stalled");

    // input backpressure only when every front stage is full and the divider is blocked
    a_full_before_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r1_vld && r2_vld && r3_vld && r4_vld && !w_div_rdy)
        else $error("input stalled with a free stage");

endmodule

[test/tb.sv]
// Self-checking testbench for the glyph source-over blender: directed and random pixels.
`timescale 1ns / 100ps

module tb;
    import gsob_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       written;
    } t_blend_px;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    // text color copy kept in step with the register writes
    logic [7:0] txt_red;
    logic [7:0] txt_green;
    logic [7:0] txt_blue;
    logic [7:0] txt_alpha;

    t_blend_px blend_q[$];
    int        mismatch_cnt = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    glyph_source_over_blend dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] mix_color(input int unsigned tc, input int unsigned dc,
                                             input int unsigned sa, input int unsigned da,
                                             input int unsigned oa);
        int unsigned num;
        int unsigned q;
        if (oa == 0) begin
            return 8'd0;
        end
        num = tc * sa * 255 + dc * da * (255 - sa);
        q = num / (oa * 255);
        // oa is truncated, so the quotient can overshoot
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic t_blend_px blend_pixel(input logic [7:0] cov, input logic [7:0] dr,
                                              input logic [7:0] dg, input logic [7:0] db,
                                              input logic [7:0] da);
        t_blend_px   px;
        int unsigned sa;
        int unsigned oa;
        if (cov < CoverMin) begin
            px = '{red: dr, green: dg, blue: db, alpha: da, written: 1'b0};
            return px;
        end
        sa = (32'(txt_alpha) * 32'(cov)) / 255;
        oa = sa + (32'(da) * (255 - sa)) / 255;
        px.red     = mix_color(32'(txt_red), 32'(dr), sa, 32'(da), oa);
        px.green   = mix_color(32'(txt_green), 32'(dg), sa, 32'(da), oa);
        px.blue    = mix_color(32'(txt_blue), 32'(db), sa, 32'(da), oa);
        px.alpha   = oa[7:0];
        px.written = 1'b1;
        return px;
    endfunction

    // result checker and receiver stall
    always @(posedge i_clk) begin
        t_blend_px got;
        t_blend_px want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{red: m_tdata[7:0], green: m_tdata[15:8], blue: m_tdata[23:16],
                    alpha: m_tdata[31:24], written: m_tuser[0]};
            if (blend_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected word: rgba %0d %0d %0d %0d written %0d",
                             got.red, got.green, got.blue, got.alpha, got.written);
            end else begin
                want = blend_q.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.alpha !== want.alpha ||
                    got.written !== want.written) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"mismatch: expected rgba %0d %0d %0d %0d written %0d, ",
                                  "got rgba %0d %0d %0d %0d written %0d"},
                                 want.red, want.green, want.blue, want.alpha, want.written,
                                 got.red, got.green, got.blue, got.alpha, got.written);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_pixel(input logic [7:0] cov, input logic [7:0] dr,
                              input logic [7:0] dg, input logic [7:0] db,
                              input logic [7:0] da);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {da, db, dg, dr, cov};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        blend_q.push_back(blend_pixel(cov, dr, dg, db, da));
    endtask

    // let the pipeline empty, then add some margin
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (blend_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_text_cfg(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic [7:0] a);
        logic [7:0] vals [4];
        t_cfg_idx   idx;
        vals = '{r, g, b, a};
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            cfg_we   <= 1'b1;
            cfg_idx  <= idx;
            cfg_data <= vals[k];
            @(posedge i_clk);
            case (idx)
                CFG_RED:   txt_red   = vals[k];
                CFG_GREEN: txt_green = vals[k];
                CFG_BLUE:  txt_blue  = vals[k];
                CFG_ALPHA: txt_alpha = vals[k];
                default:   ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_pixel();
        logic [7:0]  cov;
        logic [7:0]  da;
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            cov = 8'($urandom_range(2));        // below threshold
        else if (r == 1)
            cov = 8'd255;
        else if (r == 2)
            cov = 8'($urandom_range(8, 3));     // near threshold
        else
            cov = 8'($urandom_range(255));
        r = $urandom_range(9);
        if (r < 2)
            da = 8'd0;
        else if (r < 4)
            da = 8'd255;
        else if (r == 4)
            da = 8'($urandom_range(3));
        else
            da = 8'($urandom_range(255));
        send_pixel(cov, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), da);
    endtask

    // reset color is opaque white
    task automatic test_default_color();
        send_pixel(8'd0, 8'd12, 8'd34, 8'd56, 8'd78);
        send_pixel(8'd2, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd3, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd10, 8'd200, 8'd77, 8'd0);
        send_pixel(8'd128, 8'd10, 8'd200, 8'd77, 8'd255);
        // tiny oa after truncation: color quotient saturates
        send_pixel(8'd3, 8'd255, 8'd255, 8'd255, 8'd1);
        send_pixel(8'd3, 8'd0, 8'd0, 8'd0, 8'd1);
        wait_drained();
    endtask

    // zero text alpha still blends; transparent dst loses its color
    task automatic test_invisible_text();
        write_text_cfg(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd90, 8'd91, 8'd92, 8'd0);
        send_pixel(8'd200, 8'd90, 8'd91, 8'd92, 8'd200);
        send_pixel(8'd1, 8'd90, 8'd91, 8'd92, 8'd0);
        send_pixel(8'd3, 8'd255, 8'd255, 8'd255, 8'd255);
        wait_drained();
        write_text_cfg(8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd200, 8'd100, 8'd50, 8'd128);
        send_pixel(8'd100, 8'd200, 8'd100, 8'd50, 8'd128);
        wait_drained();
    endtask

    task automatic test_faint_text();
        write_text_cfg(8'd255, 8'd0, 8'd128, 8'd1);
        send_pixel(8'd255, 8'd33, 8'd66, 8'd99, 8'd0);
        send_pixel(8'd3, 8'd33, 8'd66, 8'd99, 8'd77);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd254);
        send_pixel(8'd254, 8'd1, 8'd2, 8'd3, 8'd0);
        wait_drained();
    endtask

    task automatic test_random_blend();
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 86, 0, 27};
        recv_pct = '{0, 0, 86, 27};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            for (int s = 0; s < 2; s++) begin
                write_text_cfg(pick_byte(), pick_byte(), pick_byte(), pick_byte());
                repeat (135) send_random_pixel();
                wait_drained();
            end
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_RED;
        cfg_data <= 8'd0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        txt_red   = 8'd255;
        txt_green = 8'd255;
        txt_blue  = 8'd255;
        txt_alpha = 8'd255;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_color();
        test_invisible_text();
        test_faint_text();
        test_random_blend();
        if (mismatch_cnt == 0)
            $display("glyph_source_over_blend regression: pass");
        else
            $display("glyph_source_over_blend regression: fail");
        $finish;
    end

    initial begin
        #3000000;
        $display("glyph_source_over_blend regression: fail");
        $finish;
    end

endmodule

[files.f]
rtl/gsob_pkg.sv
rtl/gsob_div.sv
rtl/glyph_source_over_blend.sv
test/tb.sv
